// ----- rtl/ec_pkg.sv -----
// shared types, constants and character classes for the expression completer
package ec_pkg;

  localparam int CP_W = 21;
  localparam int CODE_W = 3;
  localparam int STACK_DEPTH_DEF = 32;

  localparam logic [CP_W-1:0] CP_DOT = CP_W'(32'h2E);
  localparam logic [CP_W-1:0] CP_NEWLINE = CP_W'(32'h0A);
  localparam logic [CP_W-1:0] CP_BACKSLASH = CP_W'(32'h5C);
  localparam logic [CP_W-1:0] CP_LPAREN = CP_W'(32'h28);
  localparam logic [CP_W-1:0] CP_RPAREN = CP_W'(32'h29);
  localparam logic [CP_W-1:0] CP_LBRACK = CP_W'(32'h5B);
  localparam logic [CP_W-1:0] CP_RBRACK = CP_W'(32'h5D);
  localparam logic [CP_W-1:0] CP_LBRACE = CP_W'(32'h7B);
  localparam logic [CP_W-1:0] CP_RBRACE = CP_W'(32'h7D);
  localparam logic [CP_W-1:0] CP_DQUOTE = CP_W'(32'h22);
  localparam logic [CP_W-1:0] CP_BQUOTE = CP_W'(32'h60);
  localparam logic [CP_W-1:0] CP_SQUOTE = CP_W'(32'h27);

  // closer codes held on the stack
  localparam logic [CODE_W-1:0] CL_PAREN = 3'd1;
  localparam logic [CODE_W-1:0] CL_BRACK = 3'd2;
  localparam logic [CODE_W-1:0] CL_BRACE = 3'd3;
  localparam logic [CODE_W-1:0] CL_DQUOTE = 3'd4;
  localparam logic [CODE_W-1:0] CL_BQUOTE = 3'd5;
  localparam logic [CODE_W-1:0] CL_SQUOTE = 3'd6;

  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic            operation;
    logic [CP_W-1:0] code_point;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] out_code_point;
    logic            out_valid;
    logic            last;
    logic            overflowed;
  } out_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic [CODE_W-1:0] code;
  } stack_cmd_t;

  function automatic logic [CP_W-1:0] closer_char(input logic [CODE_W-1:0] code);
    logic [CP_W-1:0] c;
    case (code)
      CL_PAREN:  c = CP_RPAREN;
      CL_BRACK:  c = CP_RBRACK;
      CL_BRACE:  c = CP_RBRACE;
      CL_DQUOTE: c = CP_DQUOTE;
      CL_BQUOTE: c = CP_BQUOTE;
      CL_SQUOTE: c = CP_SQUOTE;
      default:   c = '0;
    endcase
    return c;
  endfunction

  function automatic logic is_space(input logic [CP_W-1:0] c);
    return (c == CP_W'(32'h20)) || (c >= CP_W'(32'h09) && c <= CP_W'(32'h0D));
  endfunction

  function automatic logic is_ident(input logic [CP_W-1:0] c);
    return (c >= CP_W'(32'h30) && c <= CP_W'(32'h39)) ||
           (c >= CP_W'(32'h41) && c <= CP_W'(32'h5A)) ||
           (c >= CP_W'(32'h61) && c <= CP_W'(32'h7A)) ||
           (c == CP_DOT) || (c == CP_W'(32'h5F));
  endfunction

  function automatic logic is_operator(input logic [CP_W-1:0] c);
    logic r;
    case (c)
      CP_W'(32'h7E), CP_W'(32'h21), CP_W'(32'h40), CP_W'(32'h24),
      CP_W'(32'h25), CP_W'(32'h5E), CP_W'(32'h26), CP_W'(32'h2B),
      CP_W'(32'h2D), CP_W'(32'h2A), CP_W'(32'h2F), CP_W'(32'h3D),
      CP_W'(32'h7C), CP_W'(32'h3C), CP_W'(32'h3E), CP_W'(32'h3F): r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ec_cell.sv -----
// one stack cell: holds a closer code, shifts down on push and up on pop
module ec_cell (
  input  logic                      clk,
  input  ec_pkg::stack_cmd_t        cmd,
  input  logic [ec_pkg::CODE_W-1:0] above,
  input  logic [ec_pkg::CODE_W-1:0] below,
  output logic [ec_pkg::CODE_W-1:0] code
);
  import ec_pkg::*;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      code <= above;
    end else if (cmd.pop) begin
      code <= below;
    end
  end

endmodule

// ----- rtl/ec_chain.sv -----
// row of stack cells; cell zero is the top of the closer stack
module ec_chain #(
  parameter int DEPTH = ec_pkg::STACK_DEPTH_DEF
) (
  input  logic                      clk,
  input  ec_pkg::stack_cmd_t        cmd,
  output logic [ec_pkg::CODE_W-1:0] top_code
);
  import ec_pkg::*;

  logic [CODE_W-1:0] codes [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [CODE_W-1:0] above;
    logic [CODE_W-1:0] below;
    if (i == 0) begin : g_first
      assign above = cmd.code;
    end else begin : g_mid_a
      assign above = codes[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_b
      assign below = codes[i+1];
    end
    ec_cell u_cell (
      .clk   (clk),
      .cmd   (cmd),
      .above (above),
      .below (below),
      .code  (codes[i])
    );
  end

  assign top_code = codes[0];

endmodule

// ----- rtl/expression_completer.sv -----
// top level of the expression completer: character classes, flags and result sequencing
// A closing bracket right after an operator is preceded by an inserted '.', which goes
// out ahead of it through the single result register.
// A finish transaction gives an optional '.' then one result per open closer
// (at most STACK_DEPTH + 1 results), or the empty marker alone. The closers
// sit in a row of STACK_DEPTH cells that shift one place on each push or pop, so the
// innermost closer is always in the first cell. No new transaction is taken while a
// finish is being flushed or an inserted '.' is ahead of its character.
module expression_completer #(
  parameter int STACK_DEPTH = ec_pkg::STACK_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  ec_pkg::in_t  in_item,
  output logic         res_valid,
  input  logic         res_ready,
  output ec_pkg::out_t res_item
);
  import ec_pkg::*;

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHAR = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0] state, state_next;
  logic [LVL_W-1:0] level, level_next;
  logic inside_string, inside_string_next;
  logic escape_pending, escape_pending_next;
  logic operator_seen, operator_seen_next;
  logic identifier_seen, identifier_seen_next;
  logic overflow_flag, overflow_flag_next;
  logic ovf_hold, ovf_hold_next;
  logic [CP_W-1:0] pend_cp, pend_cp_next;
  logic res_valid_next;
  out_t res_item_next;

  stack_cmd_t cmd;
  logic [CODE_W-1:0] top_code;
  logic [CP_W-1:0] c, top_cp;
  logic slot_free, accept, full, top_match, is_closer, opener, push_ok;
  logic [CODE_W-1:0] open_code;

  ec_chain #(.DEPTH(STACK_DEPTH)) u_chain (
    .clk      (clk),
    .cmd      (cmd),
    .top_code (top_code)
  );

  assign slot_free = !res_valid || res_ready;
  assign in_ready = (state == S_IDLE) && slot_free;
  assign accept = in_valid && in_ready;
  assign c = in_item.code_point;
  assign top_cp = closer_char(top_code);
  assign full = (level >= LVL_W'(STACK_DEPTH));
  // an empty stack never matches, also not for a NUL character
  assign top_match = (level != '0) && (c == top_cp);
  assign is_closer = (c == CP_RPAREN) || (c == CP_RBRACK) || (c == CP_RBRACE);

  always_comb begin
    opener = 1'b1;
    case (c)
      CP_LPAREN: open_code = CL_PAREN;
      CP_LBRACK: open_code = CL_BRACK;
      CP_LBRACE: open_code = CL_BRACE;
      CP_DQUOTE: open_code = CL_DQUOTE;
      CP_BQUOTE: open_code = CL_BQUOTE;
      CP_SQUOTE: open_code = CL_SQUOTE;
      default: begin
        open_code = '0;
        opener = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    level_next = level;
    inside_string_next = inside_string;
    escape_pending_next = escape_pending;
    operator_seen_next = operator_seen;
    identifier_seen_next = identifier_seen;
    overflow_flag_next = overflow_flag;
    ovf_hold_next = ovf_hold;
    pend_cp_next = pend_cp;
    res_valid_next = res_valid && !res_ready;
    res_item_next = res_item;
    cmd = '{push: 1'b0, pop: 1'b0, code: open_code};
    push_ok = 1'b0;

    case (state)
      S_IDLE: begin
        if (accept && in_item.operation == OP_FINISH) begin
          ovf_hold_next = overflow_flag;
          inside_string_next = 1'b0;
          escape_pending_next = 1'b0;
          operator_seen_next = 1'b0;
          identifier_seen_next = 1'b0;
          overflow_flag_next = 1'b0;
          res_valid_next = 1'b1;
          res_item_next.out_valid = 1'b1;
          res_item_next.overflowed = overflow_flag;
          if (operator_seen) begin
            res_item_next.out_code_point = CP_DOT;
            res_item_next.last = (level == '0);
            if (level != '0) begin
              state_next = S_FLUSH;
            end
          end else if (level == '0) begin
            res_item_next.out_code_point = '0;
            res_item_next.out_valid = 1'b0;
            res_item_next.last = 1'b1;
          end else begin
            res_item_next.out_code_point = top_cp;
            res_item_next.last = (level == LVL_W'(1));
            cmd.pop = 1'b1;
            level_next = level - LVL_W'(1);
            if (level != LVL_W'(1)) begin
              state_next = S_FLUSH;
            end
          end
        end else if (accept) begin
          if (is_space(c)) begin
            if (!identifier_seen || c == CP_NEWLINE) begin
              identifier_seen_next = 1'b0;
              res_valid_next = 1'b1;
              res_item_next = '{out_code_point: c, out_valid: 1'b1, last: 1'b1,
                                overflowed: overflow_flag};
            end
          end else begin
            if (inside_string) begin
              if (escape_pending) begin
                escape_pending_next = 1'b0;
              end else if (c == CP_BACKSLASH) begin
                escape_pending_next = 1'b1;
              end else if (top_match) begin
                inside_string_next = 1'b0;
                cmd.pop = 1'b1;
                level_next = level - LVL_W'(1);
              end
            end else begin
              operator_seen_next = is_operator(c);
              identifier_seen_next = is_ident(c);
              if (top_match) begin
                cmd.pop = 1'b1;
                level_next = level - LVL_W'(1);
              end else if (opener) begin
                if (full) begin
                  overflow_flag_next = 1'b1;
                end else begin
                  push_ok = 1'b1;
                  cmd.push = 1'b1;
                  level_next = level + LVL_W'(1);
                end
                // quotes open a string only when the push went through
                if (open_code == CL_DQUOTE || open_code == CL_BQUOTE ||
                    open_code == CL_SQUOTE) begin
                  inside_string_next = push_ok;
                end
              end
            end
            res_valid_next = 1'b1;
            if (operator_seen && is_closer) begin
              res_item_next = '{out_code_point: CP_DOT, out_valid: 1'b1, last: 1'b0,
                                overflowed: overflow_flag_next};
              pend_cp_next = c;
              ovf_hold_next = overflow_flag_next;
              state_next = S_CHAR;
            end else begin
              res_item_next = '{out_code_point: c, out_valid: 1'b1, last: 1'b1,
                                overflowed: overflow_flag_next};
            end
          end
        end
      end
      S_CHAR: begin
        if (slot_free) begin
          res_valid_next = 1'b1;
          res_item_next = '{out_code_point: pend_cp, out_valid: 1'b1, last: 1'b1,
                            overflowed: ovf_hold};
          state_next = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          res_valid_next = 1'b1;
          res_item_next = '{out_code_point: top_cp, out_valid: 1'b1,
                            last: (level == LVL_W'(1)), overflowed: ovf_hold};
          cmd.pop = 1'b1;
          level_next = level - LVL_W'(1);
          if (level == LVL_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      inside_string <= 1'b0;
      escape_pending <= 1'b0;
      operator_seen <= 1'b0;
      identifier_seen <= 1'b0;
      overflow_flag <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      inside_string <= inside_string_next;
      escape_pending <= escape_pending_next;
      operator_seen <= operator_seen_next;
      identifier_seen <= identifier_seen_next;
      overflow_flag <= overflow_flag_next;
      res_valid <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ovf_hold <= ovf_hold_next;
    pend_cp <= pend_cp_next;
    res_item <= res_item_next;
  end

endmodule
